// File: sv/lrir_pkg.sv
// Shared types and constants of the Lehmer range random number generator.
package lrir_pkg;

  // Generator arithmetic.
  localparam int unsigned STATE_W   = 31;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned MULT_W    = 16;
  localparam int unsigned PROD_W    = STATE_W + MULT_W;
  localparam int unsigned ALU_W     = WORD_W + 2;
  localparam int unsigned DIV_STEPS = STATE_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic [MULT_W-1:0]  LEHMER_MULT = 16'd48271;
  localparam logic [STATE_W-1:0] LEHMER_MOD  = 31'h7FFF_FFFF;
  localparam logic [STATE_W-1:0] SEED_RESET  = 31'd1;

  // Operation of the shared adder.
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ORDER,
    ST_SPAN,
    ST_RED_SUM,
    ST_RED_FOLD,
    ST_DIV,
    ST_ADD
  } seq_state_t;

endpackage

// File: sv/lehmer_random_in_range.sv
// Top level of the Lehmer range random number generator with its sequencer.
//
// Each request carries two signed bounds and yields one random value from the lower
// bound up to but not including the higher one. A request with equal bounds answers
// with that bound and leaves the generator alone. Otherwise it runs these steps: order
// the bounds, form the span while the state is multiplied by 48271, fold the product
// modulo 2^31-1 in a sum and a subtract step, 31 steps of a restoring remainder, and
// one final add, every add and subtract on one shared 34-bit adder. The block takes
// no new request until the current one has been handed to the output register, which
// holds a result until it is taken. Writing seed_value reloads the generator state;
// it is accepted whenever no request is in progress. Reset loads a seed of 1.
module lehmer_random_in_range
  import lrir_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [STATE_W-1:0]        seed_value,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [WORD_W-1:0]  bound_low,
  input  logic signed [WORD_W-1:0]  bound_high,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [WORD_W-1:0]  random_value
);

  seq_state_t state, state_next;

  logic [WORD_W-1:0]  req_a;
  logic [WORD_W-1:0]  req_b;
  logic [WORD_W-1:0]  lo;
  logic [WORD_W-1:0]  hi;
  logic [WORD_W-1:0]  span;
  logic [WORD_W-1:0]  rem;
  logic [STATE_W-1:0] gen_state;
  logic [STATE_W-1:0] dividend;
  logic [CNT_W-1:0]   cnt;

  alu_op_t          alu_op;
  logic [ALU_W-1:0] alu_a;
  logic [ALU_W-1:0] alu_b;
  logic [ALU_W-1:0] alu_res;
  logic             alu_neg;

  logic              mul_en;
  logic [PROD_W-1:0] prod;

  logic in_fire;
  logic cfg_fire;
  logic out_free;
  logic bounds_equal;

  assign in_ready     = (state == ST_IDLE);
  assign cfg_ready    = (state == ST_IDLE);
  assign in_fire      = in_valid && in_ready;
  assign cfg_fire     = cfg_valid && cfg_ready;
  assign out_free     = !out_valid || out_ready;
  assign bounds_equal = (req_a == req_b);
  assign alu_neg      = alu_res[ALU_W-1];
  assign mul_en       = (state == ST_SPAN);

  lrir_alu u_alu (
    .op  (alu_op),
    .opa (alu_a),
    .opb (alu_b),
    .res (alu_res)
  );

  lrir_mul u_mul (
    .clk     (clk),
    .en      (mul_en),
    .operand (gen_state),
    .prod    (prod)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and the operands of the shared adder.
  always_comb begin
    state_next = state;
    alu_op     = ALU_SUB;
    alu_a      = '0;
    alu_b      = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_ORDER;
        end
      end
      ST_ORDER: begin
        // Signed compare of the two bounds.
        alu_a = {{2{req_a[WORD_W-1]}}, req_a};
        alu_b = {{2{req_b[WORD_W-1]}}, req_b};
        state_next = bounds_equal ? ST_ADD : ST_SPAN;
      end
      ST_SPAN: begin
        alu_a = {2'b00, hi};
        alu_b = {2'b00, lo};
        state_next = ST_RED_SUM;
      end
      ST_RED_SUM: begin
        // Fold the high part of the product onto the low part.
        alu_op = ALU_ADD;
        alu_a  = ALU_W'(prod[PROD_W-1:STATE_W]);
        alu_b  = ALU_W'(prod[STATE_W-1:0]);
        state_next = ST_RED_FOLD;
      end
      ST_RED_FOLD: begin
        alu_a = {2'b00, rem};
        alu_b = ALU_W'(LEHMER_MOD);
        state_next = ST_DIV;
      end
      ST_DIV: begin
        // One restoring remainder step.
        alu_a = {1'b0, rem, dividend[STATE_W-1]};
        alu_b = {2'b00, span};
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        alu_op = ALU_ADD;
        alu_a  = {2'b00, lo};
        alu_b  = {2'b00, rem};
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Generator state: reset and seed writes load it, the fold step advances it.
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= SEED_RESET;
    end else if (cfg_fire) begin
      gen_state <= seed_value;
    end else if (state == ST_RED_FOLD) begin
      gen_state <= alu_neg ? rem[STATE_W-1:0] : alu_res[STATE_W-1:0];
    end
  end

  // Datapath registers of the current request.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_a <= bound_low;
      req_b <= bound_high;
    end
    unique case (state)
      ST_ORDER: begin
        if (bounds_equal) begin
          lo  <= req_b;
          rem <= '0;
        end else if (!alu_neg) begin
          lo <= req_b;
          hi <= req_a;
        end else begin
          lo <= req_a;
          hi <= req_b;
        end
      end
      ST_SPAN: begin
        span <= alu_res[WORD_W-1:0];
      end
      ST_RED_SUM: begin
        rem <= alu_res[WORD_W-1:0];
      end
      ST_RED_FOLD: begin
        dividend <= alu_neg ? rem[STATE_W-1:0] : alu_res[STATE_W-1:0];
        rem      <= '0;
        cnt      <= '0;
      end
      ST_DIV: begin
        rem      <= alu_neg ? {rem[WORD_W-2:0], dividend[STATE_W-1]}
                            : alu_res[WORD_W-1:0];
        dividend <= {dividend[STATE_W-2:0], 1'b0};
        cnt      <= cnt + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Output register holds a result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_ADD && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ADD && out_free) begin
      random_value <= alu_res[WORD_W-1:0];
    end
  end

endmodule

// File: sv/lrir_alu.sv
// Shared add/subtract unit used by every add, subtract and compare step of the sequencer.
module lrir_alu
  import lrir_pkg::*;
(
  input  alu_op_t          op,
  input  logic [ALU_W-1:0] opa,
  input  logic [ALU_W-1:0] opb,
  output logic [ALU_W-1:0] res
);

  // Subtraction is addition of the inverted operand with a carry in.
  logic [ALU_W-1:0] opb_eff;
  logic [ALU_W-1:0] cin;

  always_comb begin
    unique case (op)
      ALU_ADD: begin
        opb_eff = opb;
        cin     = '0;
      end
      ALU_SUB: begin
        opb_eff = ~opb;
        cin     = ALU_W'(1);
      end
      default: begin
        opb_eff = opb;
        cin     = '0;
      end
    endcase
  end

  assign res = opa + opb_eff + cin;

endmodule

// File: sv/lrir_mul.sv
// Registered multiplier that scales the generator state by the Lehmer constant.
module lrir_mul
  import lrir_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [STATE_W-1:0] operand,
  output logic [PROD_W-1:0]  prod
);

  // The product is captured when the sequencer asks for it.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(operand) * PROD_W'(LEHMER_MULT);
    end
  end

endmodule
